// ===== hw/rtl/sap_pkg.sv =====
// ============================================================================
// sap_pkg
// Shared types and constants for the sexagesimal angle text parser.
// ============================================================================
`default_nettype none

package sap_pkg;

    localparam int NumberBits = 16;
    localparam int AngleBits  = 24;
    localparam int SecPerUnit = 3600;
    localparam int SecPerMin  = 60;
    localparam int MaxHours   = 23;
    localparam int MaxDegrees = 90;
    localparam int MaxMag     = 8388607;

    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] Ch0     = 8'h30;
    localparam logic [7:0] Ch9     = 8'h39;
    localparam logic [7:0] ChD     = 8'h64;
    localparam logic [7:0] ChH     = 8'h68;
    localparam logic [7:0] ChM     = 8'h6D;
    localparam logic [7:0] ChS     = 8'h73;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NEG_HOURS = 3'd1,
        ST_MISSING   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BADCHAR   = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_UNIT       = 3'd1,
        PH_AFTER_UNIT = 3'd2,
        PH_MIN        = 3'd3,
        PH_AFTER_MIN  = 3'd4,
        PH_SEC        = 3'd5,
        PH_DONE       = 3'd6
    } t_phase;

    typedef struct packed {
        logic    neg;
        t_status status;
    } t_fin_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/sap_char_if.sv =====
// ============================================================================
// sap_char_if
// Character stream channel: one string character per word.
// ============================================================================
`default_nettype none

interface sap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       angle_kind;
    logic       last;

    modport source (output valid, character, angle_kind, last, input ready);
    modport sink   (input valid, character, angle_kind, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sap_angle_if.sv =====
// ============================================================================
// sap_angle_if
// Result channel: signed angle in seconds and parse status per word.
// ============================================================================
`default_nettype none

interface sap_angle_if;
    import sap_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [AngleBits-1:0] angle_seconds;
    t_status                     status;

    modport source (output valid, angle_seconds, status, input ready);
    modport sink   (input valid, angle_seconds, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sap_parser.sv =====
// ============================================================================
// sap_parser
// Per-character parse state machine with decimal accumulators. Presents the
// final counts and status combinationally on the word carrying the last flag.
// ============================================================================
`default_nettype none

module sap_parser #(
    parameter int NUMBER_BITS = sap_pkg::NumberBits
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [7:0]             i_character,
    input  wire logic                   i_angle_kind,
    input  wire logic                   i_last,
    output logic [NUMBER_BITS-1:0]      o_unit,
    output logic [NUMBER_BITS-1:0]      o_minute,
    output logic [NUMBER_BITS-1:0]      o_second,
    output sap_pkg::t_fin_ctl           o_ctl
);
    import sap_pkg::*;

    localparam int NB = NUMBER_BITS;

    t_phase          r_phase, n_phase;
    logic            r_neg, n_neg;
    logic            r_kind, n_kind;
    logic [NB-1:0]   r_unit, n_unit;
    logic [NB-1:0]   r_min, n_min;
    logic [NB-1:0]   r_sec, n_sec;
    logic            r_seen, n_seen;
    t_status         r_err, n_err;

    logic            w_is_digit;
    logic [3:0]      w_dv;
    logic            w_kind;
    logic [7:0]      w_unit_letter;
    logic [NB-1:0]   w_unit_max;
    logic [NB-1:0]   w_acc_src;
    logic [NB+3:0]   w_acc_ext;
    logic [NB+3:0]   w_acc_sum;
    logic            w_acc_ovf;

    assign w_is_digit    = (i_character >= Ch0) && (i_character <= Ch9);
    assign w_dv          = i_character[3:0];
    assign w_kind        = (r_phase == PH_START) ? i_angle_kind : r_kind;
    assign w_unit_letter = w_kind ? ChD : ChH;
    assign w_unit_max    = w_kind ? NB'(MaxDegrees) : NB'(MaxHours);

    always_comb begin
        case (r_phase)
            PH_MIN:  w_acc_src = r_min;
            PH_SEC:  w_acc_src = r_sec;
            default: w_acc_src = r_unit;
        endcase
    end

    assign w_acc_ext = {4'b0000, w_acc_src};
    assign w_acc_sum = (w_acc_ext << 3) + (w_acc_ext << 1) + {{NB{1'b0}}, w_dv};
    assign w_acc_ovf = |w_acc_sum[NB+3:NB];

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_kind  = r_kind;
        n_unit  = r_unit;
        n_min   = r_min;
        n_sec   = r_sec;
        n_seen  = r_seen;
        n_err   = r_err;
        if (r_err == ST_OK) begin
            n_kind = w_kind;
            case (r_phase)
                PH_START: begin
                    n_phase = PH_UNIT;
                    if (i_character == ChPlus) begin
                        n_seen = 1'b0;
                    end else if (i_character == ChMinus) begin
                        if (!w_kind) n_err = ST_NEG_HOURS;
                        else         n_neg = 1'b1;
                    end else if (w_is_digit) begin
                        n_seen = 1'b1;
                        n_unit = NB'(w_dv);
                    end else begin
                        n_err = ST_MISSING;
                    end
                end
                PH_UNIT: begin
                    if (w_is_digit) begin
                        n_seen = 1'b1;
                        if (w_acc_ovf) n_err  = ST_OVERFLOW;
                        else           n_unit = w_acc_sum[NB-1:0];
                    end else if (!r_seen) begin
                        n_err = ST_MISSING;
                    end else if (i_character == w_unit_letter) begin
                        n_phase = PH_AFTER_UNIT;
                    end else begin
                        n_err = ST_BADCHAR;
                    end
                end
                PH_AFTER_UNIT: begin
                    if (w_is_digit) begin
                        n_phase = PH_MIN;
                        n_min   = NB'(w_dv);
                    end else begin
                        n_err = ST_MISSING;
                    end
                end
                PH_MIN: begin
                    if (w_is_digit) begin
                        if (w_acc_ovf) n_err = ST_OVERFLOW;
                        else           n_min = w_acc_sum[NB-1:0];
                    end else if (i_character == ChM) begin
                        n_phase = PH_AFTER_MIN;
                    end else begin
                        n_err = ST_BADCHAR;
                    end
                end
                PH_AFTER_MIN: begin
                    if (w_is_digit) begin
                        n_phase = PH_SEC;
                        n_sec   = NB'(w_dv);
                    end else begin
                        n_err = ST_MISSING;
                    end
                end
                PH_SEC: begin
                    if (w_is_digit) begin
                        if (w_acc_ovf) n_err = ST_OVERFLOW;
                        else           n_sec = w_acc_sum[NB-1:0];
                    end else if (i_character == ChS) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_err = ST_BADCHAR;
                    end
                end
                default: begin
                    n_err = ST_BADCHAR;
                end
            endcase
            if (n_err == ST_OK && n_unit > w_unit_max) n_err = ST_RANGE;
            if (n_err == ST_OK && n_kind && n_unit == NB'(MaxDegrees)
                && (n_min != '0 || n_sec != '0)) n_err = ST_RANGE;
        end
    end

    always_comb begin
        o_unit     = n_unit;
        o_minute   = n_min;
        o_second   = n_sec;
        o_ctl.neg  = n_neg;
        if (n_err == ST_OK && n_phase == PH_UNIT && !n_seen) o_ctl.status = ST_MISSING;
        else                                                 o_ctl.status = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_kind  <= 1'b0;
            r_unit  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_seen  <= 1'b0;
            r_err   <= ST_OK;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_kind  <= n_kind;
            r_unit  <= n_unit;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_seen  <= n_seen;
            r_err   <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sap_result.sv =====
// ============================================================================
// sap_result
// Three-stage result pipeline: capture final counts, sum to seconds, then
// magnitude check, zeroing and sign. Each stage advances when the next frees.
// ============================================================================
`default_nettype none

module sap_result #(
    parameter int NUMBER_BITS = sap_pkg::NumberBits
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [NUMBER_BITS-1:0]             i_unit,
    input  wire logic [NUMBER_BITS-1:0]             i_minute,
    input  wire logic [NUMBER_BITS-1:0]             i_second,
    input  wire sap_pkg::t_fin_ctl                  i_ctl,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [sap_pkg::AngleBits-1:0]    o_angle_seconds,
    output sap_pkg::t_status                        o_status
);
    import sap_pkg::*;

    localparam int NB = NUMBER_BITS;
    localparam int TW = (NB + 13 > AngleBits + 1) ? NB + 13 : AngleBits + 1;

    logic                  r_s1_valid;
    logic [NB-1:0]         r_s1_unit, r_s1_min, r_s1_sec;
    t_fin_ctl              r_s1_ctl;
    logic                  r_s2_valid;
    logic [TW-1:0]         r_s2_total;
    t_fin_ctl              r_s2_ctl;
    logic                  r_o_valid;
    logic [AngleBits-1:0]  r_o_angle;
    t_status               r_o_status;

    logic                  w_en1, w_en2, w_en_o;
    logic [TW-1:0]         w_total;
    t_status               w_status;
    logic [AngleBits-1:0]  w_mag;
    logic [AngleBits-1:0]  w_angle;

    assign w_en_o  = !r_o_valid || i_ready;
    assign w_en2   = !r_s2_valid || w_en_o;
    assign w_en1   = !r_s1_valid || w_en2;
    assign o_ready = w_en1;

    assign w_total = TW'(r_s1_unit) * TW'(SecPerUnit)
                   + TW'(r_s1_min) * TW'(SecPerMin)
                   + TW'(r_s1_sec);

    always_comb begin
        if (r_s2_ctl.status == ST_OK && r_s2_total > TW'(MaxMag)) w_status = ST_OVERFLOW;
        else                                                      w_status = r_s2_ctl.status;
        w_mag   = (w_status == ST_OK) ? r_s2_total[AngleBits-1:0] : '0;
        w_angle = r_s2_ctl.neg ? (AngleBits'(0) - w_mag) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_en1)  r_s1_valid <= i_valid;
            if (w_en2)  r_s2_valid <= r_s1_valid;
            if (w_en_o) r_o_valid  <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_unit <= i_unit;
            r_s1_min  <= i_minute;
            r_s1_sec  <= i_second;
            r_s1_ctl  <= i_ctl;
        end
        if (w_en2 && r_s1_valid) begin
            r_s2_total <= w_total;
            r_s2_ctl   <= r_s1_ctl;
        end
        if (w_en_o && r_s2_valid) begin
            r_o_angle  <= w_angle;
            r_o_status <= w_status;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_angle_seconds = r_o_angle;
    assign o_status        = r_o_status;

endmodule

`default_nettype wire

// ===== hw/rtl/sexagesimal_angle_text_parser.sv =====
// ============================================================================
// sexagesimal_angle_text_parser
// Parses an hours/degrees-minutes-seconds angle string, one character per
// word, into signed total seconds and a status.
// ============================================================================
// Takes one character word every clock cycle unless stalled. Characters
// without the last flag only advance the parse state and are never stalled
// by a busy result path except when the three-entry result pipeline is full
// and the output is held. The word carrying the last flag yields one result
// word via capture, seconds sum and range/sign stages; a new string may start
// on the very next cycle. Strings of any length are accepted back to back.
`default_nettype none

module sexagesimal_angle_text_parser #(
    parameter int NUMBER_BITS = sap_pkg::NumberBits
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sap_char_if.sink    i_char,
    sap_angle_if.source o_angle
);
    import sap_pkg::*;

    logic                   w_take;
    logic                   w_res_ready;
    logic [NUMBER_BITS-1:0] w_unit, w_min, w_sec;
    t_fin_ctl               w_ctl;

    assign i_char.ready = w_res_ready;
    assign w_take       = i_char.valid && w_res_ready;

    sap_parser #(.NUMBER_BITS(NUMBER_BITS)) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_character  (i_char.character),
        .i_angle_kind (i_char.angle_kind),
        .i_last       (i_char.last),
        .o_unit       (w_unit),
        .o_minute     (w_min),
        .o_second     (w_sec),
        .o_ctl        (w_ctl)
    );

    sap_result #(.NUMBER_BITS(NUMBER_BITS)) u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_take && i_char.last),
        .o_ready         (w_res_ready),
        .i_unit          (w_unit),
        .i_minute        (w_min),
        .i_second        (w_sec),
        .i_ctl           (w_ctl),
        .o_valid         (o_angle.valid),
        .i_ready         (o_angle.ready),
        .o_angle_seconds (o_angle.angle_seconds),
        .o_status        (o_angle.status)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_angle.valid)
        else $error("result valid after reset");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle.valid && o_angle.status != ST_OK) |-> (o_angle.angle_seconds == '0))
        else $error("nonzero angle with error status");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_angle.valid && o_angle.ready) |-> i_char.ready)
        else $error("input stalled while output drains");
`endif

endmodule

`default_nettype wire
